/* rtl/core/blir_pkg.sv */
// blir_pkg: shared types and constants of the bounded list
// depends on nothing; used by blir_cell, blir_ctrl and bounded_list_insert_remove
`default_nettype none

package blir_pkg;

  localparam int Depth    = 64;
  localparam int ElemW    = 32;
  localparam int IdxW     = $clog2(Depth);
  localparam int CntW     = $clog2(Depth) + 1;
  localparam int OpW      = 2;
  localparam int StatusW  = 2;

  localparam logic [CntW-1:0] CapReset = CntW'(Depth);

  typedef enum logic [OpW-1:0] {
    OpInsert = 2'd0,
    OpRemove = 2'd1,
    OpRead   = 2'd2,
    OpClear  = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StBadIndex = 2'd1,
    StFull     = 2'd2,
    StEmpty    = 2'd3
  } status_e;

  // command handed to every cell in the row
  typedef struct packed {
    logic             ins;   // insert: shift up above the position
    logic             rem;   // remove: shift down from the position
    logic [ElemW-1:0] elem;  // word written at the position on insert
  } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/blir_cell.sv */
// blir_cell: one storage cell of the list row
// depends on blir_pkg for the command struct and word width
`default_nettype none

module blir_cell (
  input  wire logic                          clk_i,
  input  wire blir_pkg::cell_cmd_t           cmd_i,
  input  wire logic                          at_pos_i,
  input  wire logic                          above_pos_i,
  input  wire logic [blir_pkg::ElemW-1:0]    left_i,
  input  wire logic [blir_pkg::ElemW-1:0]    right_i,
  output      logic [blir_pkg::ElemW-1:0]    word_o
);

  logic [blir_pkg::ElemW-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (cmd_i.ins) begin
      if (at_pos_i) begin
        word_d = cmd_i.elem;
      end else if (above_pos_i) begin
        word_d = left_i;
      end
    end else if (cmd_i.rem && (at_pos_i || above_pos_i)) begin
      word_d = right_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

/* rtl/core/blir_ctrl.sv */
// blir_ctrl: operation decode, index checks and next count
// depends on blir_pkg for op and status codes
`default_nettype none

module blir_ctrl (
  input  wire logic [blir_pkg::OpW-1:0]    op_i,
  input  wire logic [blir_pkg::IdxW-1:0]   index_i,
  input  wire logic [blir_pkg::ElemW-1:0]  element_i,
  input  wire logic [blir_pkg::CntW-1:0]   count_i,
  input  wire logic [blir_pkg::CntW-1:0]   cap_i,
  output      blir_pkg::cell_cmd_t         cmd_o,
  output      blir_pkg::status_e           status_o,
  output      logic                        rd_ok_o,
  output      logic [blir_pkg::CntW-1:0]   count_o
);

  logic [blir_pkg::CntW-1:0] idx_ext;

  assign idx_ext = blir_pkg::CntW'(index_i);

  always_comb begin
    cmd_o.ins  = 1'b0;
    cmd_o.rem  = 1'b0;
    cmd_o.elem = element_i;
    status_o   = blir_pkg::StOk;
    rd_ok_o    = 1'b0;
    count_o    = count_i;
    unique case (blir_pkg::op_e'(op_i))
      blir_pkg::OpInsert: begin
        if (idx_ext > count_i) begin
          status_o = blir_pkg::StBadIndex;
        end else if (count_i >= cap_i) begin
          status_o = blir_pkg::StFull;
        end else begin
          cmd_o.ins = 1'b1;
          count_o   = count_i + blir_pkg::CntW'(1);
        end
      end
      blir_pkg::OpRemove, blir_pkg::OpRead: begin
        if (count_i == '0) begin
          status_o = blir_pkg::StEmpty;
        end else if (idx_ext >= count_i) begin
          status_o = blir_pkg::StBadIndex;
        end else if (blir_pkg::op_e'(op_i) == blir_pkg::OpRemove) begin
          cmd_o.rem = 1'b1;
          count_o   = count_i - blir_pkg::CntW'(1);
        end else begin
          rd_ok_o = 1'b1;
        end
      end
      blir_pkg::OpClear: begin
        count_o = '0;
      end
      default: begin
        status_o = blir_pkg::StOk;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/bounded_list_insert_remove.sv */
// bounded_list_insert_remove: bounded list as a row of cells; uses blir_pkg, blir_ctrl, blir_cell
// the result beat is registered and comes with done_o in the cycle after start is taken
// throughput: one operation per cycle; each cell picks its own word, a neighbor or the
//   new element, so an insert or remove shifts the whole row at once
// busy is always low and the receiver cannot stall; reset clears count and strobe,
//   capacity resets to the built depth, cell words stay undefined until written
`default_nettype none

module bounded_list_insert_remove (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration: capacity register
  input  wire logic                          cfg_we_i,
  input  wire logic [blir_pkg::CntW-1:0]     cfg_wdata_i,
  // command side
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [blir_pkg::OpW-1:0]      op_i,
  input  wire logic [blir_pkg::IdxW-1:0]     index_i,
  input  wire logic [blir_pkg::ElemW-1:0]    element_i,
  // result side
  output      logic                          done_o,
  output      logic [blir_pkg::StatusW-1:0]  status_o,
  output      logic [blir_pkg::ElemW-1:0]    read_data_o,
  output      logic [blir_pkg::CntW-1:0]     count_o,
  output      logic                          is_full_o,
  output      logic                          is_empty_o
);

  // list state
  logic [blir_pkg::CntW-1:0] count_q, count_d;
  logic [blir_pkg::CntW-1:0] cap_q;
  logic [blir_pkg::CntW-1:0] cap_eff;

  // result beat registers
  logic                         done_q;
  blir_pkg::status_e            status_q;
  logic [blir_pkg::ElemW-1:0]   rdata_q;
  logic                         full_q, empty_q;

  // decode outputs
  blir_pkg::cell_cmd_t          dec_cmd, cell_cmd;
  blir_pkg::status_e            dec_status;
  logic                         dec_rd_ok;
  logic [blir_pkg::CntW-1:0]    dec_count;
  logic                         accept;

  // cell row
  logic [blir_pkg::ElemW-1:0]   words   [blir_pkg::Depth];
  logic [blir_pkg::Depth-1:0]   at_pos;
  logic [blir_pkg::Depth-1:0]   above_pos;
  logic [blir_pkg::ElemW-1:0]   rd_word;

  // never stalls: one operation every cycle
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // capacity of zero acts as one, above depth acts as depth
  always_comb begin
    priority if (cap_q == '0) begin
      cap_eff = blir_pkg::CntW'(1);
    end else if (cap_q > blir_pkg::CntW'(blir_pkg::Depth)) begin
      cap_eff = blir_pkg::CntW'(blir_pkg::Depth);
    end else begin
      cap_eff = cap_q;
    end
  end

  blir_ctrl u_ctrl (
    .op_i      (op_i),
    .index_i   (index_i),
    .element_i (element_i),
    .count_i   (count_q),
    .cap_i     (cap_eff),
    .cmd_o     (dec_cmd),
    .status_o  (dec_status),
    .rd_ok_o   (dec_rd_ok),
    .count_o   (dec_count)
  );

  // cells only move when a beat is really taken
  always_comb begin
    cell_cmd      = dec_cmd;
    cell_cmd.ins  = dec_cmd.ins & accept;
    cell_cmd.rem  = dec_cmd.rem & accept;
  end

  assign count_d = accept ? dec_count : count_q;

  // row of cells, each compares its own fixed place with the index
  for (genvar g = 0; g < blir_pkg::Depth; g++) begin : g_cell
    logic [blir_pkg::ElemW-1:0] left_w, right_w;

    assign at_pos[g]    = (index_i == blir_pkg::IdxW'(g));
    assign above_pos[g] = (blir_pkg::IdxW'(g) > index_i);

    // row ends hold their own word
    if (g == 0) begin : g_first
      assign left_w = words[g];
    end else begin : g_mid_l
      assign left_w = words[g-1];
    end
    if (g == blir_pkg::Depth - 1) begin : g_last
      assign right_w = words[g];
    end else begin : g_mid_r
      assign right_w = words[g+1];
    end

    blir_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cell_cmd),
      .at_pos_i    (at_pos[g]),
      .above_pos_i (above_pos[g]),
      .left_i      (left_w),
      .right_i     (right_w),
      .word_o      (words[g])
    );
  end

  // read select: and-or over the row, one-hot on the index
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < blir_pkg::Depth; i++) begin
      rd_word = rd_word | (words[i] & {blir_pkg::ElemW{at_pos[i]}});
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= blir_pkg::CapReset;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // result payload, loaded with each taken beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= dec_status;
      rdata_q  <= dec_rd_ok ? rd_word : '0;
      full_q   <= (dec_count >= cap_eff);
      empty_q  <= (dec_count == '0);
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign read_data_o = rdata_q;
  assign count_o     = count_q;
  assign is_full_o   = full_q;
  assign is_empty_o  = empty_q;

endmodule

`default_nettype wire

/* bench/blir_list_checker.sv */
// blir_list_checker: watches the command, config and result beats of the bounded list,
// predicts every result from its own copy of the list and compares field by field
// depends on blir_pkg
`timescale 1ns / 100ps

module blir_list_checker
  import blir_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CntW-1:0]     cfg_wdata_i,
  input  logic                start,
  input  logic                busy,
  input  logic [OpW-1:0]      op_i,
  input  logic [IdxW-1:0]     index_i,
  input  logic [ElemW-1:0]    element_i,
  input  logic                done_o,
  input  logic [StatusW-1:0]  status_o,
  input  logic [ElemW-1:0]    read_data_o,
  input  logic [CntW-1:0]     count_o,
  input  logic                is_full_o,
  input  logic                is_empty_o,
  output int                  fail_count_o,
  output int                  outstanding_o,
  output int                  list_len_o
);

  typedef struct {
    status_e          status;
    logic [ElemW-1:0] data;
    logic [CntW-1:0]  count;
    logic             full;
    logic             empty;
  } list_result_t;

  list_result_t     awaited_q[$];
  logic [ElemW-1:0] list_words[Depth];
  int               list_len;
  logic [CntW-1:0]  list_cap;

  initial begin
    fail_count_o  = 0;
    outstanding_o = 0;
    list_len_o    = 0;
  end

  // zero acts as one, anything above the built depth as the depth
  function automatic int usable_capacity();
    int c;
    c = int'(list_cap);
    if (c == 0) c = 1;
    if (c > Depth) c = Depth;
    return c;
  endfunction

  task automatic apply_list_op(input op_e op, input int idx, input logic [ElemW-1:0] elem);
    list_result_t r;
    int           cap;
    cap      = usable_capacity();
    r.status = StOk;
    r.data   = '0;
    case (op)
      OpInsert: begin
        if (idx > list_len) r.status = StBadIndex;
        else if (list_len >= cap) r.status = StFull;
        else begin
          for (int i = list_len; i > idx; i--) list_words[i] = list_words[i-1];
          list_words[idx] = elem;
          list_len++;
        end
      end
      OpRemove: begin
        if (list_len == 0) r.status = StEmpty;
        else if (idx >= list_len) r.status = StBadIndex;
        else begin
          for (int i = idx; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      OpRead: begin
        if (list_len == 0) r.status = StEmpty;
        else if (idx >= list_len) r.status = StBadIndex;
        else r.data = list_words[idx];
      end
      default: list_len = 0;
    endcase
    r.count = CntW'(list_len);
    r.full  = (list_len >= cap);
    r.empty = (list_len == 0);
    awaited_q.push_back(r);
  endtask

  task automatic report_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    fail_count_o++;
  endtask

  task automatic check_result();
    list_result_t e;
    if (awaited_q.size() == 0) begin
      $display("%0t: result beat with nothing awaited, status %0h count %0h",
               $time, status_o, count_o);
      fail_count_o++;
      return;
    end
    e = awaited_q.pop_front();
    if (status_o !== e.status)       report_field("status", e.status, status_o);
    if (read_data_o !== e.data)      report_field("read_data", e.data, read_data_o);
    if (count_o !== e.count)         report_field("count", e.count, count_o);
    if (is_full_o !== e.full)        report_field("is_full", e.full, is_full_o);
    if (is_empty_o !== e.empty)      report_field("is_empty", e.empty, is_empty_o);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_q.delete();
      list_len      = 0;
      list_cap      = CapReset;
      outstanding_o = 0;
      list_len_o    = 0;
    end else begin
      // a result beat belongs to a command taken on an earlier edge
      if (done_o === 1'b1) check_result();
      if (start && !busy) apply_list_op(op_e'(op_i), int'(index_i), element_i);
      if (cfg_we_i) list_cap = cfg_wdata_i;
      outstanding_o = awaited_q.size();
      list_len_o    = list_len;
    end
  end

endmodule

/* bench/tb_bounded_list_insert_remove.sv */
// tb_bounded_list_insert_remove: drives commands and capacity writes into the bounded list
// and gives the verdict; prediction and comparison live in blir_list_checker
// depends on blir_pkg, blir_list_checker and bounded_list_insert_remove
`timescale 1ns / 100ps

module tb_bounded_list_insert_remove;
  import blir_pkg::*;

  localparam int CycleLimit = 200000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CntW-1:0]     cfg_wdata_i;
  logic                start;
  logic                busy;
  logic [OpW-1:0]      op_i;
  logic [IdxW-1:0]     index_i;
  logic [ElemW-1:0]    element_i;
  logic                done_o;
  logic [StatusW-1:0]  status_o;
  logic [ElemW-1:0]    read_data_o;
  logic [CntW-1:0]     count_o;
  logic                is_full_o;
  logic                is_empty_o;

  int fail_count;
  int outstanding;
  int list_len;
  int idle_pct;
  int cycles;

  bounded_list_insert_remove i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .index_i     (index_i),
    .element_i   (element_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .read_data_o (read_data_o),
    .count_o     (count_o),
    .is_full_o   (is_full_o),
    .is_empty_o  (is_empty_o)
  );

  // checker sits beside the block and only listens
  blir_list_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .index_i       (index_i),
    .element_i     (element_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .read_data_o   (read_data_o),
    .count_o       (count_o),
    .is_full_o     (is_full_o),
    .is_empty_o    (is_empty_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .list_len_o    (list_len)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog on the whole run
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one command beat; entered and left at a falling edge, start stays high on exit so
  // back-to-back beats need no gap, the caller lowers it when the burst ends
  task automatic send_cmd(input op_e op, input int idx, input logic [ElemW-1:0] elem);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start     = 1'b1;
    op_i      = op;
    index_i   = IdxW'(idx);
    element_i = elem;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // stop sending and hold off until every awaited result beat is back
  task automatic drain();
    start = 1'b0;
    wait (outstanding == 0);
    @(negedge clk_i);
  endtask

  // capacity only changes with the list idle
  task automatic set_capacity(input int cap);
    drain();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = CntW'(cap);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // mostly well-formed indices drawn from the live count, some fully random ones;
  // ins_w steers whether the list grows or shrinks over the phase
  task automatic random_phase(input int cap, input int n_items, input int ins_w,
                              input int clr_w, input int idle);
    int   r;
    int   idx;
    int   hi;
    op_e  op;
    set_capacity(cap);
    idle_pct = idle;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (r < clr_w) op = OpClear;
      else if (r < clr_w + ins_w) op = OpInsert;
      else if (r < clr_w + ins_w + (100 - clr_w - ins_w) / 2) op = OpRemove;
      else op = OpRead;
      if ($urandom_range(0, 9) < 8) begin
        if (op == OpInsert) hi = (list_len > Depth - 1) ? Depth - 1 : list_len;
        else hi = (list_len == 0) ? 0 : list_len - 1;
        idx = $urandom_range(0, hi);
      end else begin
        idx = $urandom_range(0, Depth - 1);
      end
      send_cmd(op, idx, $urandom);
      // now and then let the pipe run dry mid-phase
      if ($urandom_range(0, 149) == 0) drain();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    start       = 1'b0;
    op_i        = OpInsert;
    index_i     = '0;
    element_i   = '0;
    idle_pct    = 23;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty list at reset capacity
    send_cmd(OpRead,   0,  32'h0);
    send_cmd(OpRemove, 0,  32'h0);
    send_cmd(OpRemove, 63, 32'h0);          // empty wins over bad index
    send_cmd(OpInsert, 1,  32'hdead_beef);  // past the end of an empty list
    send_cmd(OpInsert, 0,  32'h0000_0000);
    send_cmd(OpInsert, 1,  32'hffff_ffff);  // append at count
    send_cmd(OpInsert, 0,  32'h5a5a_c3c3);  // front insert shifts all up
    send_cmd(OpInsert, 1,  32'h1234_5678);  // middle insert
    for (int i = 0; i < 4; i++) send_cmd(OpRead, i, 32'h0);
    send_cmd(OpRead,   4,  32'h0);          // one past the end
    send_cmd(OpRead,   63, 32'h0);
    send_cmd(OpRemove, 1,  32'h0);          // middle remove shifts down
    send_cmd(OpRemove, 3,  32'h0);          // equal to count
    send_cmd(OpRead,   1,  32'h0);
    send_cmd(OpClear,  17, 32'hffff_ffff);
    send_cmd(OpRead,   0,  32'h0);

    // directed: one-entry list, full against bad index
    set_capacity(1);
    send_cmd(OpInsert, 0, 32'ha5a5_a5a5);
    send_cmd(OpInsert, 0, 32'h0f0f_0f0f);   // full
    send_cmd(OpInsert, 2, 32'h0f0f_0f0f);   // bad index beats full
    send_cmd(OpInsert, 1, 32'h0f0f_0f0f);   // append onto a full list
    send_cmd(OpRead,   0, 32'h0);
    send_cmd(OpRemove, 0, 32'h0);

    // random phases: capacity, items, insert weight, clear weight, idle percent
    random_phase(64,  150, 60, 1, 23);
    random_phase(127, 150, 70, 0, 0);       // long burst, no gaps, fills to depth
    random_phase(3,   60,  20, 0, 23);      // capacity dropped under the count
    random_phase(0,   60,  40, 3, 23);      // zero behaves as one
    random_phase(1,   40,  45, 3, 23);
    random_phase(2,   60,  45, 3, 23);
    random_phase(100, 120, 50, 2, 23);      // above depth behaves as depth
    random_phase(64,  130, 45, 3, 23);
    random_phase(33,  80,  55, 2, 23);

    drain();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/blir_pkg.sv
rtl/core/blir_cell.sv
rtl/core/blir_ctrl.sv
rtl/core/bounded_list_insert_remove.sv
bench/blir_list_checker.sv
bench/tb_bounded_list_insert_remove.sv
